FILE: hw/rtl/rrpr_pkg.sv
// ----------------------------------------------------------------------------
// rrpr_pkg: shared types and constants for the round-robin partition reader
// Field widths, default sizes, operation and register codes, queue entry kinds.
// ----------------------------------------------------------------------------
package rrpr_pkg;

    // Default sizes handed to the top level parameters.
    localparam int MAX_PARTITIONS_DEF = 16;
    localparam int OFFSET_BITS_DEF    = 32;

    // Fixed field widths of the ports.
    localparam int PART_W     = 4;
    localparam int COUNT_W    = 32;
    localparam int ACT_W      = 5;
    localparam int WIN_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Largest active count that the 5-bit register can express.
    localparam int SCAN_MAX = 31;

    // Depth of the queue between front and back end.
    localparam int Q_DEPTH = 2;

    // Reset values of the configuration registers.
    localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;
    localparam logic [WIN_W-1:0] WIN_RESET = 16'd16;

    typedef enum logic {
        OP_PULL      = 1'b0,
        OP_SET_COUNT = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_PARTITIONS = 1'b0,
        CFG_PREFETCH_WINDOW   = 1'b1
    } t_cfg_idx;

    // Kind of work handed from the front end to the back end.
    typedef enum logic [1:0] {
        Q_SET_COUNT = 2'd0,
        Q_PULL_HIT  = 2'd1,
        Q_PULL_MISS = 2'd2
    } t_q_kind;

    localparam int KIND_W = 2;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef enum logic {
        F_IDLE = 1'b0,
        F_PULL = 1'b1
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE   = 2'd0,
        B_LOAD   = 2'd1,
        B_UPDATE = 2'd2
    } t_back_state;

endpackage

FILE: hw/rtl/round_robin_partition_reader_core.sv
// ----------------------------------------------------------------------------
// round_robin_partition_reader_core: round-robin reader over event partitions
// Tracks per-partition event counts, read offsets and prefetch marks, and
// hands out the next unread event in round-robin order with prefetch hints.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                      Payload
// --------  ---------  -----------------------------  -----------------------------
// item in   input      i_start && !o_busy             i_operation, i_partition,
//                                                     i_event_count
// result    output     o_valid (one cycle, no stall)  o_found, o_chosen_partition,
//                                                     o_event_offset,
//                                                     o_prefetch_request,
//                                                     o_prefetch_base
// config    input      i_cfg_we                       i_cfg_index, i_cfg_wdata
//
// An accepted count update for a partition in range drops into the work
// queue; updates can follow each other every cycle until the queue fills, and
// the back end retires each one with a RAM read, then a compare and write.
// A pull waits until the queue and back end have drained so the nonempty bits
// are current and searches them combinationally; a hit then passes through the
// RAM read, the offset increment, and the mark update and write before its
// registered result, while a miss returns its result after the RAM read.
// While the stored pointer lies at or beyond the active count, every pull folds
// its scan start back by repeated subtraction; the pointer moves only on a hit.
// Reset is synchronous and active low; it clears the pointer, valid bits and
// nonempty bits at once, so there is no clearing pass. Results cannot be
// stalled: o_valid is a single-cycle strobe.
// ----------------------------------------------------------------------------
module round_robin_partition_reader_core #(
    parameter int MAX_PARTITIONS = rrpr_pkg::MAX_PARTITIONS_DEF,
    parameter int OFFSET_BITS    = rrpr_pkg::OFFSET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_operation,
    input  logic [rrpr_pkg::PART_W-1:0]       i_partition,
    input  logic [rrpr_pkg::COUNT_W-1:0]      i_event_count,

    output logic                              o_valid,
    output logic                              o_found,
    output logic [rrpr_pkg::PART_W-1:0]       o_chosen_partition,
    output logic [rrpr_pkg::COUNT_W-1:0]      o_event_offset,
    output logic                              o_prefetch_request,
    output logic [rrpr_pkg::COUNT_W-1:0]      o_prefetch_base,

    input  logic                              i_cfg_we,
    input  logic [rrpr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rrpr_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int AW     = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int SCAN_N = (MAX_PARTITIONS < rrpr_pkg::SCAN_MAX) ? MAX_PARTITIONS
                          : rrpr_pkg::SCAN_MAX;
    localparam int QW     = rrpr_pkg::KIND_W + AW + OFFSET_BITS;

    logic [rrpr_pkg::ACT_W-1:0] r_active;
    logic [rrpr_pkg::WIN_W-1:0] r_window;
    logic [rrpr_pkg::ACT_W-1:0] act_min1;
    logic [rrpr_pkg::ACT_W-1:0] active_n;

    logic                  q_push;
    logic [QW-1:0]         q_push_data;
    logic                  q_pop;
    logic [QW-1:0]         q_head;
    rrpr_pkg::t_q_stat     q_stat;
    logic                  back_idle;
    logic [SCAN_N-1:0]     nonempty;

    // Configuration registers; writes to unknown indexes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= rrpr_pkg::ACT_RESET;
            r_window <= rrpr_pkg::WIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rrpr_pkg::CFG_ACTIVE_PARTITIONS: r_active <= i_cfg_wdata[rrpr_pkg::ACT_W-1:0];
                rrpr_pkg::CFG_PREFETCH_WINDOW:   r_window <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective active count: zero counts as one, clamp to the partition count.
    assign act_min1 = (r_active == '0) ? rrpr_pkg::ACT_W'(1) : r_active;
    assign active_n = ({4'b0, act_min1} > 9'(MAX_PARTITIONS))
                    ? rrpr_pkg::ACT_W'(MAX_PARTITIONS) : act_min1;

    rrpr_front #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .OFFSET_BITS    (OFFSET_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_operation   (i_operation),
        .i_partition   (i_partition),
        .i_event_count (i_event_count),
        .o_busy        (o_busy),
        .i_active_n    (active_n),
        .i_q_stat      (q_stat),
        .i_back_idle   (back_idle),
        .i_nonempty    (nonempty),
        .o_push        (q_push),
        .o_push_data   (q_push_data)
    );

    rrpr_queue #(
        .WIDTH (QW),
        .DEPTH (rrpr_pkg::Q_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_stat      (q_stat)
    );

    rrpr_back #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .OFFSET_BITS    (OFFSET_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_head           (q_head),
        .i_q_stat           (q_stat),
        .o_pop              (q_pop),
        .o_idle             (back_idle),
        .o_nonempty         (nonempty),
        .i_window           (r_window),
        .o_valid            (o_valid),
        .o_found            (o_found),
        .o_chosen_partition (o_chosen_partition),
        .o_event_offset     (o_event_offset),
        .o_prefetch_request (o_prefetch_request),
        .o_prefetch_base    (o_prefetch_base)
    );

endmodule

FILE: hw/rtl/rrpr_ram.sv
// ----------------------------------------------------------------------------
// rrpr_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module rrpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/rrpr_queue.sv
// ----------------------------------------------------------------------------
// rrpr_queue: short work queue between front end and back end
// Register-based FIFO; head entry always visible, pop and push in the same cycle.
// ----------------------------------------------------------------------------
module rrpr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rrpr_pkg::Q_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [WIDTH-1:0]      i_push_data,
    input  logic                  i_pop,
    output logic [WIDTH-1:0]      o_head,
    output rrpr_pkg::t_q_stat     o_stat
);

    localparam int QAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QCW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QCW-1:0]   r_cnt;
    logic [QAW-1:0]   n_wp;
    logic [QAW-1:0]   n_rp;
    logic [QCW-1:0]   n_cnt;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push && (r_cnt != QCW'(DEPTH));
    assign do_pop  = i_pop && (r_cnt != '0);

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == QAW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == QAW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == QCW'(DEPTH));

endmodule

FILE: hw/rtl/rrpr_front.sv
// ----------------------------------------------------------------------------
// rrpr_front: item intake and round-robin partition search
// Decodes items, queues count updates, searches the nonempty bits for pulls.
// ----------------------------------------------------------------------------
module rrpr_front #(
    parameter int MAX_PARTITIONS = rrpr_pkg::MAX_PARTITIONS_DEF,
    parameter int OFFSET_BITS    = rrpr_pkg::OFFSET_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_operation,
    input  logic [rrpr_pkg::PART_W-1:0]           i_partition,
    input  logic [rrpr_pkg::COUNT_W-1:0]          i_event_count,
    output logic                                  o_busy,
    input  logic [rrpr_pkg::ACT_W-1:0]            i_active_n,
    input  rrpr_pkg::t_q_stat                     i_q_stat,
    input  logic                                  i_back_idle,
    input  logic [((MAX_PARTITIONS < rrpr_pkg::SCAN_MAX) ? MAX_PARTITIONS
                  : rrpr_pkg::SCAN_MAX)-1:0]      i_nonempty,
    output logic                                  o_push,
    output logic [rrpr_pkg::KIND_W
                  + ((MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1)
                  + OFFSET_BITS-1:0]              o_push_data
);

    localparam int AW     = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int SCAN_N = (MAX_PARTITIONS < rrpr_pkg::SCAN_MAX) ? MAX_PARTITIONS
                          : rrpr_pkg::SCAN_MAX;
    localparam int PW     = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
    localparam int CW     = rrpr_pkg::ACT_W + 1;

    rrpr_pkg::t_front_state r_state;
    rrpr_pkg::t_front_state n_state;
    logic [PW-1:0]          r_ptr;
    logic [PW-1:0]          n_ptr;
    logic [PW-1:0]          r_scan;
    logic [PW-1:0]          n_scan;

    logic                   accept;
    logic                   is_set;
    logic [8:0]             part9;
    logic                   in_range;
    logic [AW-1:0]          set_addr;
    logic [OFFSET_BITS+rrpr_pkg::COUNT_W-1:0] count_ext;
    logic                   drained;
    logic [CW-1:0]          n_ext;
    logic [CW-1:0]          ptr_ext;
    logic                   ptr_high;
    logic [SCAN_N-1:0]      cand_all;
    logic [SCAN_N-1:0]      cand_hi;
    logic [SCAN_N-1:0]      cand;
    logic [SCAN_N-1:0]      lowest;
    logic [PW-1:0]          hit_idx;
    logic                   hit;
    logic [CW-1:0]          idx_inc;
    logic [AW+PW-1:0]       hit_addr_ext;

    assign accept    = i_start && !o_busy;
    assign is_set    = (i_operation == rrpr_pkg::OP_SET_COUNT);
    assign part9     = {5'b0, i_partition};
    assign in_range  = (part9 < 9'(MAX_PARTITIONS));
    assign set_addr  = part9[AW-1:0];
    assign count_ext = {{OFFSET_BITS{1'b0}}, i_event_count};
    assign drained   = i_q_stat.empty && i_back_idle;
    assign n_ext     = {1'b0, i_active_n};
    assign ptr_ext   = CW'(r_scan);
    assign ptr_high  = (ptr_ext >= n_ext);

    // Rotating priority search: first candidate at or after the scan start,
    // else the first candidate overall.
    always_comb begin
        for (int i = 0; i < SCAN_N; i++) begin
            cand_all[i] = i_nonempty[i] && (CW'(i) < n_ext);
            cand_hi[i]  = cand_all[i] && (CW'(i) >= ptr_ext);
        end
        cand   = (|cand_hi) ? cand_hi : cand_all;
        lowest = cand & (~cand + SCAN_N'(1));
        hit    = |cand;
        hit_idx = '0;
        for (int i = 0; i < SCAN_N; i++) begin
            if (lowest[i]) begin
                hit_idx = hit_idx | PW'(i);
            end
        end
    end

    assign idx_inc      = CW'(hit_idx) + CW'(1);
    assign hit_addr_ext = {{AW{1'b0}}, hit_idx};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rrpr_pkg::F_IDLE: begin
                if (accept && !is_set) begin
                    n_state = rrpr_pkg::F_PULL;
                end
            end
            rrpr_pkg::F_PULL: begin
                if (!ptr_high && drained) begin
                    n_state = rrpr_pkg::F_IDLE;
                end
            end
            default: n_state = rrpr_pkg::F_IDLE;
        endcase
    end

    // Outputs, pointer and scan start.
    always_comb begin
        o_busy      = (r_state != rrpr_pkg::F_IDLE) || i_q_stat.full;
        o_push      = 1'b0;
        o_push_data = '0;
        n_ptr       = r_ptr;
        n_scan      = r_scan;
        case (r_state)
            rrpr_pkg::F_IDLE: begin
                if (accept && is_set && in_range) begin
                    o_push      = 1'b1;
                    o_push_data = {rrpr_pkg::Q_SET_COUNT, set_addr,
                                   count_ext[OFFSET_BITS-1:0]};
                end else if (accept && !is_set) begin
                    // Start the scan from the stored pointer; the pointer
                    // itself only moves when a pull finds an event.
                    n_scan = r_ptr;
                end
            end
            rrpr_pkg::F_PULL: begin
                if (ptr_high) begin
                    // Fold the scan start back below the active count.
                    n_scan = PW'(ptr_ext - n_ext);
                end else if (drained) begin
                    o_push = 1'b1;
                    if (hit) begin
                        o_push_data = {rrpr_pkg::Q_PULL_HIT, hit_addr_ext[AW-1:0],
                                       {OFFSET_BITS{1'b0}}};
                        n_ptr = (idx_inc == n_ext) ? '0 : idx_inc[PW-1:0];
                    end else begin
                        o_push_data = {rrpr_pkg::Q_PULL_MISS, {AW{1'b0}},
                                       {OFFSET_BITS{1'b0}}};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrpr_pkg::F_IDLE;
            r_ptr   <= '0;
            r_scan  <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_scan  <= n_scan;
        end
    end

endmodule

FILE: hw/rtl/rrpr_back.sv
// ----------------------------------------------------------------------------
// rrpr_back: per-partition state update and result generation
// Holds counts, offsets and marks in RAM; keeps the nonempty bits current.
// ----------------------------------------------------------------------------
module rrpr_back #(
    parameter int MAX_PARTITIONS = rrpr_pkg::MAX_PARTITIONS_DEF,
    parameter int OFFSET_BITS    = rrpr_pkg::OFFSET_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [rrpr_pkg::KIND_W
                  + ((MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1)
                  + OFFSET_BITS-1:0]              i_q_head,
    input  rrpr_pkg::t_q_stat                     i_q_stat,
    output logic                                  o_pop,
    output logic                                  o_idle,
    output logic [((MAX_PARTITIONS < rrpr_pkg::SCAN_MAX) ? MAX_PARTITIONS
                  : rrpr_pkg::SCAN_MAX)-1:0]      o_nonempty,
    input  logic [rrpr_pkg::WIN_W-1:0]            i_window,
    output logic                                  o_valid,
    output logic                                  o_found,
    output logic [rrpr_pkg::PART_W-1:0]           o_chosen_partition,
    output logic [rrpr_pkg::COUNT_W-1:0]          o_event_offset,
    output logic                                  o_prefetch_request,
    output logic [rrpr_pkg::COUNT_W-1:0]          o_prefetch_base
);

    localparam int AW     = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int SCAN_N = (MAX_PARTITIONS < rrpr_pkg::SCAN_MAX) ? MAX_PARTITIONS
                          : rrpr_pkg::SCAN_MAX;
    localparam int OB     = OFFSET_BITS;
    localparam int QW     = rrpr_pkg::KIND_W + AW + OB;
    localparam int SUMW   = OB + rrpr_pkg::WIN_W + 1;
    localparam int OW     = rrpr_pkg::COUNT_W;

    rrpr_pkg::t_back_state r_state;
    rrpr_pkg::t_back_state n_state;
    rrpr_pkg::t_q_kind     r_kind;
    rrpr_pkg::t_q_kind     n_kind;
    rrpr_pkg::t_q_kind     head_kind;
    logic [AW-1:0]         r_addr;
    logic [AW-1:0]         n_addr;
    logic [AW-1:0]         head_addr;
    logic [OB-1:0]         r_data;
    logic [OB-1:0]         n_data;
    logic                  r_cnt_vq;
    logic                  n_cnt_vq;
    logic                  r_ofs_vq;
    logic                  n_ofs_vq;
    logic [OB-1:0]         r_off;
    logic [OB-1:0]         n_off;
    logic [OB-1:0]         r_nxt;
    logic [OB-1:0]         n_nxt;
    logic [OB-1:0]         r_mark;
    logic [OB-1:0]         n_mark;
    logic [OB-1:0]         r_cnt;
    logic [OB-1:0]         n_cnt;
    logic [MAX_PARTITIONS-1:0] r_cnt_vld;
    logic [MAX_PARTITIONS-1:0] n_cnt_vld;
    logic [MAX_PARTITIONS-1:0] r_ofs_vld;
    logic [MAX_PARTITIONS-1:0] n_ofs_vld;
    logic [SCAN_N-1:0]     r_ne;
    logic [SCAN_N-1:0]     n_ne;

    logic                  r_valid;
    logic                  n_valid;
    logic                  r_found;
    logic                  n_found;
    logic [rrpr_pkg::PART_W-1:0] r_part;
    logic [rrpr_pkg::PART_W-1:0] n_part;
    logic [OW-1:0]         r_offset;
    logic [OW-1:0]         n_offset;
    logic                  r_pf;
    logic                  n_pf;
    logic [OW-1:0]         r_pf_start;
    logic [OW-1:0]         n_pf_start;

    logic                  ram_re;
    logic                  cnt_we;
    logic                  ofs_we;
    logic [OB-1:0]         cnt_rd;
    logic [2*OB-1:0]       ofs_rd;
    logic [2*OB-1:0]       ofs_wdata;
    logic [OB-1:0]         ld_off;
    logic [OB-1:0]         ld_mark;
    logic [OB-1:0]         ld_cnt;
    logic                  ne_we;
    logic                  ne_val;
    logic                  pf_hit;
    logic [SUMW-1:0]       mark_sum;
    logic [OB-1:0]         mark_sat;
    logic [OB-1:0]         mark_new;
    logic [OB+OW-1:0]      off_ext;
    logic [OB+OW-1:0]      nxt_ext;
    logic [AW+rrpr_pkg::PART_W-1:0] part_ext;

    assign head_kind = rrpr_pkg::t_q_kind'(i_q_head[QW-1 -: rrpr_pkg::KIND_W]);
    assign head_addr = i_q_head[OB +: AW];

    // Offset and mark share one row; counts sit in a RAM of their own.
    rrpr_ram #(
        .WIDTH (OB),
        .DEPTH (MAX_PARTITIONS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_addr),
        .i_wdata (r_data),
        .i_re    (ram_re),
        .i_raddr (head_addr),
        .o_rdata (cnt_rd)
    );

    rrpr_ram #(
        .WIDTH (2 * OB),
        .DEPTH (MAX_PARTITIONS)
    ) u_ofs_ram (
        .i_clk   (i_clk),
        .i_we    (ofs_we),
        .i_waddr (r_addr),
        .i_wdata (ofs_wdata),
        .i_re    (ram_re),
        .i_raddr (head_addr),
        .o_rdata (ofs_rd)
    );

    // Entries never written read as zero.
    assign ld_off  = r_ofs_vq ? ofs_rd[2*OB-1:OB] : '0;
    assign ld_mark = r_ofs_vq ? ofs_rd[OB-1:0]    : '0;
    assign ld_cnt  = r_cnt_vq ? cnt_rd            : '0;

    // Prefetch mark: one window past the advanced offset, saturating.
    assign pf_hit    = (r_nxt >= r_mark);
    assign mark_sum  = SUMW'(r_nxt) + SUMW'(i_window);
    assign mark_sat  = (|mark_sum[SUMW-1:OB]) ? {OB{1'b1}} : mark_sum[OB-1:0];
    assign mark_new  = pf_hit ? mark_sat : r_mark;
    assign ofs_wdata = {r_nxt, mark_new};

    assign off_ext  = {{OW{1'b0}}, r_off};
    assign nxt_ext  = {{OW{1'b0}}, r_nxt};
    assign part_ext = {{rrpr_pkg::PART_W{1'b0}}, r_addr};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rrpr_pkg::B_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = rrpr_pkg::B_LOAD;
                end
            end
            rrpr_pkg::B_LOAD: begin
                n_state = (r_kind == rrpr_pkg::Q_PULL_HIT) ? rrpr_pkg::B_UPDATE
                                                           : rrpr_pkg::B_IDLE;
            end
            rrpr_pkg::B_UPDATE: n_state = rrpr_pkg::B_IDLE;
            default:            n_state = rrpr_pkg::B_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        o_pop      = 1'b0;
        ram_re     = 1'b0;
        cnt_we     = 1'b0;
        ofs_we     = 1'b0;
        ne_we      = 1'b0;
        ne_val     = 1'b0;
        n_kind     = r_kind;
        n_addr     = r_addr;
        n_data     = r_data;
        n_cnt_vq   = r_cnt_vq;
        n_ofs_vq   = r_ofs_vq;
        n_off      = r_off;
        n_nxt      = r_nxt;
        n_mark     = r_mark;
        n_cnt      = r_cnt;
        n_cnt_vld  = r_cnt_vld;
        n_ofs_vld  = r_ofs_vld;
        n_valid    = 1'b0;
        n_found    = r_found;
        n_part     = r_part;
        n_offset   = r_offset;
        n_pf       = r_pf;
        n_pf_start = r_pf_start;
        case (r_state)
            rrpr_pkg::B_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop    = 1'b1;
                    ram_re   = 1'b1;
                    n_kind   = head_kind;
                    n_addr   = head_addr;
                    n_data   = i_q_head[OB-1:0];
                    n_cnt_vq = r_cnt_vld[head_addr];
                    n_ofs_vq = r_ofs_vld[head_addr];
                end
            end
            rrpr_pkg::B_LOAD: begin
                case (r_kind)
                    rrpr_pkg::Q_SET_COUNT: begin
                        cnt_we            = 1'b1;
                        n_cnt_vld[r_addr] = 1'b1;
                        ne_we             = 1'b1;
                        ne_val            = (ld_off < r_data);
                    end
                    rrpr_pkg::Q_PULL_HIT: begin
                        n_off  = ld_off;
                        n_nxt  = ld_off + 1'b1;
                        n_mark = ld_mark;
                        n_cnt  = ld_cnt;
                    end
                    default: begin
                        // Nothing to read anywhere: all-zero result.
                        n_valid    = 1'b1;
                        n_found    = 1'b0;
                        n_part     = '0;
                        n_offset   = '0;
                        n_pf       = 1'b0;
                        n_pf_start = '0;
                    end
                endcase
            end
            rrpr_pkg::B_UPDATE: begin
                ofs_we            = 1'b1;
                n_ofs_vld[r_addr] = 1'b1;
                ne_we             = 1'b1;
                ne_val            = (r_nxt < r_cnt);
                n_valid           = 1'b1;
                n_found           = 1'b1;
                n_part            = part_ext[rrpr_pkg::PART_W-1:0];
                n_offset          = off_ext[OW-1:0];
                n_pf              = pf_hit;
                n_pf_start        = pf_hit ? nxt_ext[OW-1:0] : '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_ne = r_ne;
        for (int i = 0; i < SCAN_N; i++) begin
            if (ne_we && (r_addr == AW'(i))) begin
                n_ne[i] = ne_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rrpr_pkg::B_IDLE;
            r_cnt_vld <= '0;
            r_ofs_vld <= '0;
            r_ne      <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt_vld <= n_cnt_vld;
            r_ofs_vld <= n_ofs_vld;
            r_ne      <= n_ne;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_addr     <= n_addr;
        r_data     <= n_data;
        r_cnt_vq   <= n_cnt_vq;
        r_ofs_vq   <= n_ofs_vq;
        r_off      <= n_off;
        r_nxt      <= n_nxt;
        r_mark     <= n_mark;
        r_cnt      <= n_cnt;
        r_found    <= n_found;
        r_part     <= n_part;
        r_offset   <= n_offset;
        r_pf       <= n_pf;
        r_pf_start <= n_pf_start;
    end

    assign o_idle             = (r_state == rrpr_pkg::B_IDLE);
    assign o_nonempty         = r_ne;
    assign o_valid            = r_valid;
    assign o_found            = r_found;
    assign o_chosen_partition = r_part;
    assign o_event_offset     = r_offset;
    assign o_prefetch_request = r_pf;
    assign o_prefetch_base    = r_pf_start;

endmodule
